@@ hw/rtl/scb_pkg.sv @@
// Package: constants, register indexes and word types of the scaled color-key sprite blitter.
package scb_pkg;

  localparam int TEX_DIM     = 64;
  localparam int PIXEL_BITS  = 32;
  localparam int STORE_DEPTH = TEX_DIM * TEX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int DIM_W       = 7;
  localparam int SCALE_W     = 16;
  localparam int OFF_W       = 12;
  localparam int IDX_W       = 12;
  localparam int DEST_W      = 13;
  localparam int FRAC_BITS   = 8;

  localparam int REM_W       = OFF_W + FRAC_BITS;
  localparam int QUO_W       = DIM_W;
  localparam int CMP_W       = SCALE_W + QUO_W;
  localparam int MUL_W       = DIM_W + SCALE_W;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Q8   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_A      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_B      = 3'd6;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  localparam logic [DIM_W-1:0]      TEX_WIDTH_RST  = 7'd64;
  localparam logic [DIM_W-1:0]      TEX_HEIGHT_RST = 7'd64;
  localparam logic [SCALE_W-1:0]    SCALE_RST      = 16'd256;
  localparam logic [PIXEL_BITS-1:0] KEY_A_RST      = 32'd16711901;
  localparam logic [PIXEL_BITS-1:0] KEY_B_RST      = 32'd16650716;

  typedef struct packed {
    logic                  cmd;
    logic [IDX_W-1:0]      texel_index;
    logic [PIXEL_BITS-1:0] texel_color;
    logic [OFF_W-1:0]      offset_x;
    logic [OFF_W-1:0]      offset_y;
  } in_word_t;

  typedef struct packed {
    logic [DEST_W-1:0]     dest_x;
    logic [DEST_W-1:0]     dest_y;
    logic [PIXEL_BITS-1:0] pixel_color;
    logic                  write_enable;
  } out_word_t;

endpackage

@@ hw/rtl/scaled_colorkey_sprite_blit.sv @@
// Top level: nearest-neighbor scaled sprite blitter with two transparent key colors.
//
// Takes one word per cycle while input is not held off, loads and draws alike, and
// returns one word per draw through the divider, RAM and output registers. The source
// texel on each axis comes from a restoring divider pipelined one quotient bit per stage;
// the texture sits in a single-port synchronous RAM that a load writes and a draw reads in
// the same stage, so words keep their order. Input is held off only while a finished word
// waits in the output register and the RAM stage holds another draw result. The texture
// RAM is not cleared: texels never loaded read as unknown.
module scaled_colorkey_sprite_blit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  scb_pkg::in_word_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output scb_pkg::out_word_t              out_data_o,
  input  logic                            cfg_we_i,
  input  logic [scb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [scb_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import scb_pkg::*;

  typedef struct packed {
    logic                  cmd;
    logic [IDX_W-1:0]      idx;
    logic [PIXEL_BITS-1:0] color;
    logic [OFF_W-1:0]      ox;
    logic [OFF_W-1:0]      oy;
    logic [REM_W-1:0]      rx;
    logic [REM_W-1:0]      ry;
    logic [QUO_W-1:0]      qx;
    logic [QUO_W-1:0]      qy;
    logic                  in_rgn;
  } stg_t;

  // configuration
  logic [DIM_W-1:0]      tex_w_q, tex_h_q;
  logic [SCALE_W-1:0]    scale_q;
  logic [OFF_W-1:0]      org_x_q, org_y_q;
  logic [PIXEL_BITS-1:0] key_a_q, key_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_w_q <= TEX_WIDTH_RST;
      tex_h_q <= TEX_HEIGHT_RST;
      scale_q <= SCALE_RST;
      org_x_q <= '0;
      org_y_q <= '0;
      key_a_q <= KEY_A_RST;
      key_b_q <= KEY_B_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TEX_WIDTH:  tex_w_q <= cfg_data_i[DIM_W-1:0];
        CFG_TEX_HEIGHT: tex_h_q <= cfg_data_i[DIM_W-1:0];
        CFG_SCALE_Q8:   scale_q <= cfg_data_i[SCALE_W-1:0];
        CFG_ORIGIN_X:   org_x_q <= cfg_data_i[OFF_W-1:0];
        CFG_ORIGIN_Y:   org_y_q <= cfg_data_i[OFF_W-1:0];
        CFG_KEY_A:      key_a_q <= cfg_data_i[PIXEL_BITS-1:0];
        CFG_KEY_B:      key_b_q <= cfg_data_i[PIXEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic                  adv;
  logic [QUO_W:0]        vld_q;
  stg_t                  stg_q [QUO_W+1];
  stg_t                  stg_d [1:QUO_W];
  logic                  m_res_q;
  logic                  m_inside_q, m_inb_q;
  logic [OFF_W-1:0]      m_ox_q, m_oy_q;
  logic [PIXEL_BITS-1:0] rdata_q;
  logic                  out_valid_q;
  out_word_t             out_q;

  assign adv        = !m_res_q || !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // divider: one quotient bit per stage on each axis
  always_comb begin
    logic [CMP_W-1:0] trial;
    trial = '0;
    for (int j = 1; j <= QUO_W; j++) begin
      stg_d[j] = stg_q[j-1];
      trial    = CMP_W'(scale_q) << (QUO_W - j);
      if (CMP_W'(stg_q[j-1].rx) >= trial) begin
        stg_d[j].rx           = REM_W'(CMP_W'(stg_q[j-1].rx) - trial);
        stg_d[j].qx[QUO_W-j]  = 1'b1;
      end
      if (CMP_W'(stg_q[j-1].ry) >= trial) begin
        stg_d[j].ry           = REM_W'(CMP_W'(stg_q[j-1].ry) - trial);
        stg_d[j].qy[QUO_W-j]  = 1'b1;
      end
    end
    stg_d[1].in_rgn =
      (MUL_W'({stg_q[0].ox, FRAC_BITS'(0)}) < MUL_W'(tex_w_q) * MUL_W'(scale_q)) &&
      (MUL_W'({stg_q[0].oy, FRAC_BITS'(0)}) < MUL_W'(tex_h_q) * MUL_W'(scale_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      m_res_q <= 1'b0;
    end else if (adv) begin
      vld_q   <= {vld_q[QUO_W-1:0], in_valid_i};
      m_res_q <= vld_q[QUO_W] && (stg_q[QUO_W].cmd == CMD_DRAW);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      stg_q[0].cmd    <= in_data_i.cmd;
      stg_q[0].idx    <= in_data_i.texel_index;
      stg_q[0].color  <= in_data_i.texel_color;
      stg_q[0].ox     <= in_data_i.offset_x;
      stg_q[0].oy     <= in_data_i.offset_y;
      stg_q[0].rx     <= {in_data_i.offset_x, FRAC_BITS'(0)};
      stg_q[0].ry     <= {in_data_i.offset_y, FRAC_BITS'(0)};
      stg_q[0].qx     <= '0;
      stg_q[0].qy     <= '0;
      stg_q[0].in_rgn <= 1'b0;
      for (int j = 1; j <= QUO_W; j++) begin
        stg_q[j] <= stg_d[j];
      end
    end
  end

  // texture RAM stage
  logic [PIXEL_BITS-1:0] tex_mem [STORE_DEPTH];
  stg_t                  last;
  logic                  mem_en, mem_wr, inb;
  logic [ADDR_W-1:0]     mem_addr;

  assign last   = stg_q[QUO_W];
  assign mem_en = adv && vld_q[QUO_W];
  assign mem_wr = (last.cmd == CMD_LOAD) && (32'(last.idx) < STORE_DEPTH);
  assign inb    = (last.qx < tex_w_q) && (last.qy < tex_h_q) &&
                  (32'(last.qx) < TEX_DIM) && (32'(last.qy) < TEX_DIM);

  always_comb begin
    if (last.cmd == CMD_LOAD) begin
      mem_addr = ADDR_W'(last.idx);
    end else begin
      mem_addr = ADDR_W'(ADDR_W'(last.qy) * ADDR_W'(TEX_DIM) + ADDR_W'(last.qx));
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_en) begin
      if (mem_wr) begin
        tex_mem[mem_addr] <= last.color;
      end else if (last.cmd == CMD_DRAW) begin
        rdata_q <= tex_mem[mem_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_inside_q <= last.in_rgn;
      m_inb_q    <= inb;
      m_ox_q     <= last.ox;
      m_oy_q     <= last.oy;
    end
  end

  // key test and output register
  logic [PIXEL_BITS-1:0] px_color;
  out_word_t             res;

  assign px_color = (m_inside_q && m_inb_q) ? rdata_q : '0;

  always_comb begin
    res.dest_x       = DEST_W'(org_x_q) + DEST_W'(m_ox_q);
    res.dest_y       = DEST_W'(org_y_q) + DEST_W'(m_oy_q);
    res.pixel_color  = px_color;
    res.write_enable = m_inside_q && (px_color != key_a_q) && (px_color != key_b_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && m_res_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && m_res_q) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
